/* sv/fsigm_pkg.sv */
// Shared types and register codes for the frame signature matcher.
package fsigm_pkg;

	// Signature register file geometry
	localparam int REG_SLOTS = 4;
	localparam int SIG_BYTES = 8;
	localparam int LEN_W     = 4;
	localparam int SLOT_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_WORD_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_WORD_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_WORD_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_WORD_3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_LENGTHS  = 3'd5;

	typedef logic [SIG_BYTES-1:0][7:0] sig_word_t;

	// Signature bytes and lengths, as seen by every cell
	typedef struct packed {
		sig_word_t [REG_SLOTS-1:0]             word;
		logic      [REG_SLOTS-1:0][LEN_W-1:0]  len;
	} sig_cfg_t;

endpackage

/* sv/frame_signature_matcher.sv */
// Top level of the frame signature matcher: config registers, cell chain, best-match tracking.
//
// Scans a frame one payload byte per cycle and, on the transfer that carries
// frame_last, produces one result: matched and the slot of the earliest-starting
// signature (lowest slot on a tie). Each byte enters a
// chain of MAX_SIG_BYTES cells, each holding one byte of the recent window and
// comparing it against all signatures at once, and the best match is updated in
// the same cycle. The result sits in an output register, so input keeps flowing
// while a result waits; the input stalls only when that register is full and the
// output side stalls. Configuration writes take effect on the next byte.
module frame_signature_matcher
	import fsigm_pkg::*;
#(
	parameter int NUM_SLOTS       = 4,
	parameter int MAX_SIG_BYTES   = 8,
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write port
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// byte input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 frame_last,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 matched,
	output logic [SLOT_W-1:0]    sig_index
);

	localparam int USE_SLOTS = (NUM_SLOTS < REG_SLOTS) ? NUM_SLOTS : REG_SLOTS;
	localparam int POS_W     = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SIG_BYTES);

	logic [2:0]         active_count_q;
	sig_cfg_t           cfg_q;

	logic [POS_W-1:0]   pos_q;
	logic               best_found_q;
	logic [POS_W-1:0]   best_start_q;
	logic [SLOT_W-1:0]  best_slot_q;

	logic               out_valid_q;
	logic               matched_q;
	logic [SLOT_W-1:0]  sig_index_q;

	logic               accept;
	logic [7:0]         chain_byte [MAX_SIG_BYTES];
	logic [REG_SLOTS-1:0] cell_hit [MAX_SIG_BYTES];

	logic [REG_SLOTS-1:0] slot_ok;
	logic [POS_W-1:0]   pos_inc;
	logic               cur_found;
	logic [LEN_W-1:0]   cur_len;
	logic [SLOT_W-1:0]  cur_slot;
	logic [POS_W-1:0]   cur_start;
	logic               take_cur;
	logic               nxt_found;
	logic [POS_W-1:0]   nxt_start;
	logic [SLOT_W-1:0]  nxt_slot;

	// Handshake: hold input only while a result waits and is stalled
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
			cfg_q          <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ACTIVE_COUNT: active_count_q <= cfg_data[2:0];
				REG_SIG_WORD_0:   cfg_q.word[0]  <= cfg_data;
				REG_SIG_WORD_1:   cfg_q.word[1]  <= cfg_data;
				REG_SIG_WORD_2:   cfg_q.word[2]  <= cfg_data;
				REG_SIG_WORD_3:   cfg_q.word[3]  <= cfg_data;
				REG_SIG_LENGTHS:  cfg_q.len      <= cfg_data[REG_SLOTS*LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell chain: cell 0 sees the incoming byte, cell d the byte d back
	assign chain_byte[0] = data_byte;

	genvar d;
	generate
		for (d = 0; d < MAX_SIG_BYTES; d++) begin : g_cell
			if (d < MAX_SIG_BYTES - 1) begin : g_mid
				fsigm_cell #(.DIST(d)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.adv      (accept),
					.clr      (frame_last),
					.byte_in  (chain_byte[d]),
					.cfg      (cfg_q),
					.byte_out (chain_byte[d+1]),
					.hit_ok   (cell_hit[d])
				);
			end else begin : g_end
				fsigm_cell #(.DIST(d)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.adv      (accept),
					.clr      (frame_last),
					.byte_in  (chain_byte[d]),
					.cfg      (cfg_q),
					.byte_out (),
					.hit_ok   (cell_hit[d])
				);
			end
		end
	endgenerate

	assign pos_inc = pos_q + POS_W'(1);

	// Slot hits this byte: enabled, length legal, fully inside the frame
	always_comb begin
		logic all_eq;
		for (int s = 0; s < REG_SLOTS; s++) begin
			all_eq = 1'b1;
			for (int c = 0; c < MAX_SIG_BYTES; c++) begin
				all_eq = all_eq & cell_hit[c][s];
			end
			slot_ok[s] = (s < USE_SLOTS) && (3'(s) < active_count_q) && all_eq &&
				(cfg_q.len[s] != '0) && (cfg_q.len[s] <= LEN_MAX) &&
				(pos_q < POS_MAX) && (pos_inc >= POS_W'(cfg_q.len[s]));
		end
	end

	// Earliest start this byte is the longest hit; lowest slot on a tie
	always_comb begin
		cur_found = 1'b0;
		cur_len   = '0;
		cur_slot  = '0;
		for (int s = 0; s < USE_SLOTS; s++) begin
			if (slot_ok[s] && (!cur_found || cfg_q.len[s] > cur_len)) begin
				cur_found = 1'b1;
				cur_len   = cfg_q.len[s];
				cur_slot  = SLOT_W'(s);
			end
		end
	end

	// Merge with the best match so far
	assign cur_start = pos_inc - POS_W'(cur_len);
	assign take_cur  = cur_found && (!best_found_q || (cur_start < best_start_q) ||
		((cur_start == best_start_q) && (cur_slot < best_slot_q)));
	assign nxt_found = best_found_q || cur_found;
	assign nxt_start = take_cur ? cur_start : best_start_q;
	assign nxt_slot  = take_cur ? cur_slot  : best_slot_q;

	// Per-frame state: position and best match, cleared at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			best_found_q <= 1'b0;
			best_start_q <= '0;
			best_slot_q  <= '0;
		end else if (accept) begin
			if (frame_last) begin
				pos_q        <= '0;
				best_found_q <= 1'b0;
				best_start_q <= '0;
				best_slot_q  <= '0;
			end else begin
				if (pos_q < POS_MAX) begin
					pos_q <= pos_inc;
				end
				best_found_q <= nxt_found;
				best_start_q <= nxt_start;
				best_slot_q  <= nxt_slot;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && frame_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_last) begin
			matched_q   <= nxt_found;
			sig_index_q <= nxt_found ? nxt_slot : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign sig_index = sig_index_q;

endmodule

/* sv/fsigm_cell.sv */
// One window cell: holds a byte, checks it against each signature, passes it on.
module fsigm_cell
	import fsigm_pkg::*;
#(
	parameter int DIST = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 clr,
	input  logic [7:0]           byte_in,
	input  sig_cfg_t             cfg,
	output logic [7:0]           byte_out,
	output logic [REG_SLOTS-1:0] hit_ok
);

	logic [7:0] byte_q;

	// Per-slot check: this cell sees the byte DIST positions back, which must
	// equal signature byte len-1-DIST; cells beyond the length always pass.
	always_comb begin
		logic [LEN_W-1:0] k;
		for (int s = 0; s < REG_SLOTS; s++) begin
			k = cfg.len[s] - LEN_W'(1) - LEN_W'(DIST);
			if (LEN_W'(DIST) >= cfg.len[s]) begin
				hit_ok[s] = 1'b1;
			end else begin
				hit_ok[s] = (byte_in == cfg.word[s][k[2:0]]);
			end
		end
	end

	// Shift stage, emptied at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (adv) begin
			byte_q <= clr ? 8'h00 : byte_in;
		end
	end

	assign byte_out = byte_q;

endmodule
